### design/qpv_pkg.sv
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared widths and constants for the quadrature period velocity core.
// ----------------------------------------------------------------------------
package qpv_pkg;

  // Field widths
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned VelBits   = 48;
  localparam int unsigned DirBits   = 2;

  // Divider step count: one quotient bit per cycle
  localparam int unsigned DivSteps  = VelBits;
  localparam int unsigned CntBits   = $clog2(DivSteps);

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataBits  = 40;
  localparam int unsigned OutDataBits = 56;

  // Item kinds carried in tuser
  localparam logic KindEdge  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // Register reset and saturation limits
  localparam logic [VelBits-1:0] ScaleReset = 48'd102943;
  localparam logic [VelBits-1:0] VelMax     = 48'h7FFF_FFFF_FFFF;
  localparam logic [VelBits-1:0] VelNegLim  = 48'h8000_0000_0000;

  // Direction codes
  localparam logic signed [DirBits-1:0] DirNeg  = -2'sd1;
  localparam logic signed [DirBits-1:0] DirZero = 2'sd0;
  localparam logic signed [DirBits-1:0] DirPos  = 2'sd1;

endpackage

### design/quadrature_period_velocity_core.sv
// ----------------------------------------------------------------------------
// quadrature_period_velocity_core
// An edge transfer is absorbed into the edge registers. A query passes through
// the interval state, the bit-serial divider, its done register and the output
// load, which waits on a stalled output; the input stays closed meanwhile.
// Edges are taken every cycle while no query runs. Reset is asynchronous:
// edge times and direction clear to zero, velocity_scale loads 102943.
// ----------------------------------------------------------------------------
// Quadrature encoder period velocity estimator. Edge items update the edge
// timestamps and direction; query items return direction * scale / interval,
// saturated to 48 signed bits.
// ----------------------------------------------------------------------------
module quadrature_period_velocity_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: velocity_scale
  input  logic                               cfg_we_i,
  input  logic [qpv_pkg::VelBits-1:0]        cfg_wdata_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [qpv_pkg::InDataBits-1:0]     s_axis_tdata,  // [0] phase_a, [1] phase_b,
                                                            // [33:2] time_us, rest zero
  input  logic                               s_axis_tuser,  // [0] kind
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [qpv_pkg::OutDataBits-1:0]    m_axis_tdata   // [47:0] velocity,
                                                            // [49:48] direction, rest zero
);

  typedef enum logic [1:0] {
    StIdle,
    StDiff,
    StDiv,
    StOut
  } state_e;

  state_e                             state_q, state_d;
  logic [qpv_pkg::VelBits-1:0]        scale_q;
  logic [qpv_pkg::TimeBits-1:0]       prev_time_q, prev_time_d;
  logic [qpv_pkg::TimeBits-1:0]       last_time_q, last_time_d;
  logic signed [qpv_pkg::DirBits-1:0] dir_q, dir_d;
  logic [qpv_pkg::TimeBits-1:0]       now_q, now_d;
  logic                               m_valid_q, m_valid_d;
  logic [qpv_pkg::VelBits-1:0]        vel_q, vel_d;
  logic signed [qpv_pkg::DirBits-1:0] out_dir_q, out_dir_d;

  logic                               s_xfer;
  logic                               in_pa, in_pb;
  logic [qpv_pkg::TimeBits-1:0]       in_time;
  logic [qpv_pkg::TimeBits-1:0]       d_edge, d_now, dt;
  logic                               div_start, div_busy, div_done;
  logic [qpv_pkg::VelBits-1:0]        quotient;
  logic [qpv_pkg::VelBits-1:0]        vel_result;

  assign in_pa   = s_axis_tdata[0];
  assign in_pb   = s_axis_tdata[1];
  assign in_time = s_axis_tdata[qpv_pkg::TimeBits+1:2];

  assign s_axis_tready = (state_q == StIdle);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Interval: larger of the last edge period and time since the last edge,
  // both wrapping modulo 2^32.
  assign d_edge = last_time_q - prev_time_q;
  assign d_now  = now_q - last_time_q;
  assign dt     = (d_edge > d_now) ? d_edge : d_now;

  assign div_start = (state_q == StDiff);

  qpv_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scale_q),
    .divisor_i  (dt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sign and saturate the unsigned quotient. A zero interval gives an
  // all-ones quotient, which lands on the saturation limits.
  always_comb begin
    unique case (dir_q)
      qpv_pkg::DirPos: begin
        vel_result = quotient[qpv_pkg::VelBits-1] ? qpv_pkg::VelMax : quotient;
      end
      qpv_pkg::DirNeg: begin
        if (quotient[qpv_pkg::VelBits-1] && (quotient[qpv_pkg::VelBits-2:0] != '0)) begin
          vel_result = qpv_pkg::VelNegLim;
        end else begin
          vel_result = '0 - quotient;
        end
      end
      default: begin
        vel_result = '0;
      end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    prev_time_d = prev_time_q;
    last_time_d = last_time_q;
    dir_d       = dir_q;
    now_d       = now_q;
    m_valid_d   = m_valid_q;
    vel_d       = vel_q;
    out_dir_d   = out_dir_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_xfer) begin
          if (s_axis_tuser == qpv_pkg::KindEdge) begin
            prev_time_d = last_time_q;
            last_time_d = in_time;
            if (in_pa == in_pb) begin
              dir_d = (dir_q == qpv_pkg::DirPos) ? qpv_pkg::DirZero : qpv_pkg::DirNeg;
            end else begin
              dir_d = (dir_q == qpv_pkg::DirNeg) ? qpv_pkg::DirZero : qpv_pkg::DirPos;
            end
          end else begin
            now_d   = in_time;
            state_d = StDiff;
          end
        end
      end
      StDiff: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          vel_d     = vel_result;
          out_dir_d = dir_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scale_q     <= qpv_pkg::ScaleReset;
      prev_time_q <= '0;
      last_time_q <= '0;
      dir_q       <= qpv_pkg::DirZero;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_time_q <= prev_time_d;
      last_time_q <= last_time_d;
      dir_q       <= dir_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    vel_q     <= vel_d;
    out_dir_q <= out_dir_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(qpv_pkg::OutDataBits - qpv_pkg::VelBits - qpv_pkg::DirBits){1'b0}},
                          out_dir_q, vel_q};

  // Input is never taken while the divider runs.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !s_axis_tready)
    else $error("input accepted while divider busy");

  // A query transfer always closes the input side on the next cycle.
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && (s_axis_tuser == qpv_pkg::KindQuery)) |=> !s_axis_tready)
    else $error("input stayed open after a query");

  // The direction register only ever holds one of the three direction codes.
  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == qpv_pkg::DirNeg) || (dir_q == qpv_pkg::DirZero) ||
    (dir_q == qpv_pkg::DirPos))
    else $error("direction holds an illegal code");

  // A zero direction result carries zero velocity.
  a_zero_dir_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_dir_q == qpv_pkg::DirZero)) |-> (vel_q == '0))
    else $error("nonzero velocity with zero direction");

endmodule

### design/qpv_divider.sv
// ----------------------------------------------------------------------------
// qpv_divider
// Radix-2 restoring divider: 48-bit dividend over 32-bit divisor, one
// quotient bit per cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module qpv_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [qpv_pkg::VelBits-1:0]     dividend_i,
  input  logic [qpv_pkg::TimeBits-1:0]    divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [qpv_pkg::VelBits-1:0]     quotient_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [qpv_pkg::CntBits-1:0]     cnt_q, cnt_d;
  logic [qpv_pkg::VelBits-1:0]     quo_q, quo_d;
  logic [qpv_pkg::TimeBits-1:0]    rem_q, rem_d;
  logic [qpv_pkg::TimeBits-1:0]    div_q, div_d;
  logic [qpv_pkg::TimeBits:0]      trial;
  logic [qpv_pkg::TimeBits:0]      diff;
  logic                            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[qpv_pkg::VelBits-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = qpv_pkg::CntBits'(qpv_pkg::DivSteps - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[qpv_pkg::VelBits-2:0], fits};
      rem_d = fits ? diff[qpv_pkg::TimeBits-1:0] : trial[qpv_pkg::TimeBits-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### dv/quadrature_period_velocity_checker.sv
// ----------------------------------------------------------------------------
// quadrature_period_velocity_checker
// Watches the configuration port and both streams of the velocity core. It
// keeps its own copy of the edge times, the direction and the scale, predicts
// the result of every accepted query and compares each output transfer with
// the oldest prediction. It reports the number of failures and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module quadrature_period_velocity_checker
  import qpv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [VelBits-1:0]     cfg_wdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [InDataBits-1:0]  s_tdata_i,   // [0] phase_a, [1] phase_b, [33:2] time_us
  input  logic                   s_tuser_i,   // [0] kind
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OutDataBits-1:0] m_tdata_i,   // [47:0] velocity, [49:48] direction
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [VelBits-1:0]        velocity;
    logic signed [DirBits-1:0] direction;
  } velocity_result_t;

  logic [VelBits-1:0]        scale_q      = ScaleReset;
  logic [TimeBits-1:0]       prev_edge_us = '0;
  logic [TimeBits-1:0]       last_edge_us = '0;
  logic signed [DirBits-1:0] dir_q        = DirZero;
  velocity_result_t          velocity_due[$];
  int                        mismatch_count = 0;

  // Velocity for a query at now_us: scale over the longer of the last edge
  // interval and the time since the last edge, saturated per direction.
  function automatic velocity_result_t velocity_of(input logic [TimeBits-1:0] now_us);
    logic [TimeBits-1:0] edge_span;
    logic [TimeBits-1:0] idle_span;
    logic [TimeBits-1:0] span;
    logic [VelBits-1:0]  quotient;
    velocity_result_t    res;
    edge_span     = last_edge_us - prev_edge_us;
    idle_span     = now_us - last_edge_us;
    span          = (edge_span > idle_span) ? edge_span : idle_span;
    res.direction = dir_q;
    res.velocity  = '0;
    if (dir_q == DirPos) begin
      quotient = (span == '0) ? VelMax : scale_q / span;
      if (quotient > VelMax) quotient = VelMax;
      res.velocity = quotient;
    end else if (dir_q == DirNeg) begin
      quotient = (span == '0) ? VelNegLim : scale_q / span;
      if (quotient > VelNegLim) quotient = VelNegLim;
      res.velocity = '0 - quotient;
    end
    return res;
  endfunction

  // Track state, predict on input transfers and compare on output transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    velocity_result_t    want;
    logic [VelBits-1:0]  got_velocity;
    logic [DirBits-1:0]  got_direction;
    logic                pa;
    logic                pb;
    if (!rst_ni) begin
      scale_q      = ScaleReset;
      prev_edge_us = '0;
      last_edge_us = '0;
      dir_q        = DirZero;
      velocity_due.delete();
      pending_o <= 0;
      errors_o  <= mismatch_count;
    end else begin
      if (cfg_we_i) scale_q = cfg_wdata_i;

      // The output side goes first so that a result meets the older query.
      if (m_tvalid_i && m_tready_i) begin
        got_velocity  = m_tdata_i[0 +: VelBits];
        got_direction = m_tdata_i[VelBits +: DirBits];
        if (velocity_due.size() == 0) begin
          $display("%0t: result with nothing expected: velocity %0d, direction %0d",
                   $time, $signed(got_velocity), $signed(got_direction));
          mismatch_count++;
        end else begin
          want = velocity_due.pop_front();
          if (got_velocity !== want.velocity) begin
            $display("%0t: velocity mismatch: expected %0d, actual %0d",
                     $time, $signed(want.velocity), $signed(got_velocity));
            mismatch_count++;
          end
          if (got_direction !== want.direction) begin
            $display("%0t: direction mismatch: expected %0d, actual %0d",
                     $time, want.direction, $signed(got_direction));
            mismatch_count++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == KindQuery) begin
          velocity_due.push_back(velocity_of(s_tdata_i[2 +: TimeBits]));
        end else begin
          pa           = s_tdata_i[0];
          pb           = s_tdata_i[1];
          prev_edge_us = last_edge_us;
          last_edge_us = s_tdata_i[2 +: TimeBits];
          // Equal levels step down, unequal levels step up; the opposite
          // sign first falls back to zero.
          if (pa == pb) dir_q = (dir_q == DirPos) ? DirZero : DirNeg;
          else          dir_q = (dir_q == DirNeg) ? DirZero : DirPos;
        end
      end

      errors_o  <= mismatch_count;
      pending_o <= velocity_due.size();
    end
  end

endmodule

### dv/quadrature_period_velocity_core_test.sv
// ----------------------------------------------------------------------------
// quadrature_period_velocity_core_test
// Drives edge and query transfers into the velocity core with random gaps and
// output stalls, sweeps the scale register through its extremes between
// phases, and takes the verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module quadrature_period_velocity_core_test;
  import qpv_pkg::*;

  localparam int unsigned ClkHalf        = 4;
  localparam int unsigned ResetCycles    = 8;
  localparam int unsigned MaxIdle        = 6;
  localparam int unsigned BurstSpan      = 48;
  localparam int unsigned SettleCycles   = 64;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned PhaseItems     = 212;
  localparam int unsigned TimeoutCycles  = 600_000;

  typedef enum int unsigned {
    TrendForward,
    TrendReverse,
    TrendMixed
  } trend_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [VelBits-1:0]     cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [InDataBits-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OutDataBits-1:0] m_tdata;
  int                     errors;
  int                     pending;

  bit                     hold_req  = 1'b0;
  bit                     tx_burst  = 1'b0;
  bit                     rx_burst  = 1'b0;
  int unsigned            tx_count  = 0;
  logic [TimeBits-1:0]    clock_us  = '0;

  quadrature_period_velocity_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  quadrature_period_velocity_checker velocity_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Free-running clock.
  always #(ClkHalf) clk_i = ~clk_i;

  // Offer one item after a random gap and hold it until the transfer.
  task automatic send_item(input logic kind, input logic pa, input logic pb,
                           input logic [TimeBits-1:0] t_us);
    int unsigned gap;
    if (tx_count % BurstSpan == 0) tx_burst = ($urandom_range(0, 3) == 0);
    tx_count++;
    gap = tx_burst ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(InDataBits - TimeBits - 2){1'b0}}, t_us, pb, pa};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop offering, wait for every result, then let a trailing edge settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write, only once the block has gone quiet.
  task automatic write_scale(input logic [VelBits-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One random item. Times mostly advance in small steps, with repeated
  // timestamps, long gaps, jumps anywhere and short backward steps mixed in.
  task automatic send_random_item(input trend_e trend);
    logic        kind;
    logic        pa;
    logic        pb;
    int unsigned pick;
    kind = ($urandom_range(0, 99) < 35) ? KindQuery : KindEdge;
    pick = $urandom_range(0, 99);
    if (pick < 55)      clock_us = clock_us + $urandom_range(1, 300);
    else if (pick < 67) clock_us = clock_us + 0;
    else if (pick < 80) clock_us = clock_us + $urandom_range(1000, 2_000_000);
    else if (pick < 90) clock_us = $urandom;
    else                clock_us = clock_us - $urandom_range(1, 64);
    pa = 1'($urandom_range(0, 1));
    pb = 1'($urandom_range(0, 1));
    // A trend keeps the direction saturated most of the time.
    if (trend != TrendMixed && $urandom_range(0, 99) < 85) begin
      pb = (trend == TrendForward) ? ~pa : pa;
    end
    send_item(kind, pa, pb, clock_us);
  endtask

  // Output side: random stalls, stall-free stretches and one long hold-off.
  initial begin : receiver
    int unsigned stall;
    int unsigned rx_count;
    rx_count = 0;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (rx_count % BurstSpan == 0) rx_burst = ($urandom_range(0, 3) == 0);
      rx_count++;
      stall = rx_burst ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready) && !hold_req);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [VelBits-1:0] phase_scale [PhaseCount];
    logic [15:0]        hi_part;
    trend_e             trend;
    hi_part = 16'($urandom);
    phase_scale[0] = '0;
    phase_scale[1] = 48'd1;
    phase_scale[2] = 48'hFFFF_FFFF_FFFF;
    phase_scale[3] = {hi_part, 32'($urandom)};
    phase_scale[4] = VelNegLim;
    phase_scale[5] = ScaleReset;
    phase_scale[6] = 48'($urandom_range(1, 1 << 24));
    phase_scale[7] = {16'($urandom), 32'($urandom)};

    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KindEdge;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset scale: zero direction, each direction
    // step, zero intervals of both signs and a timestamp wrap.
    send_item(KindQuery, 1'b0, 1'b0, 32'd0);
    send_item(KindEdge,  1'b1, 1'b0, 32'd100);
    send_item(KindQuery, 1'b0, 1'b0, 32'd100);
    send_item(KindQuery, 1'b1, 1'b1, 32'd5000);
    send_item(KindEdge,  1'b1, 1'b1, 32'd5100);
    send_item(KindQuery, 1'b0, 1'b0, 32'd5200);
    send_item(KindEdge,  1'b0, 1'b0, 32'd5300);
    send_item(KindQuery, 1'b0, 1'b0, 32'd5300);
    send_item(KindEdge,  1'b0, 1'b0, 32'd5300);
    send_item(KindQuery, 1'b0, 1'b1, 32'd5300);
    send_item(KindEdge,  1'b0, 1'b1, 32'd5300);
    send_item(KindEdge,  1'b1, 1'b0, 32'd5300);
    send_item(KindQuery, 1'b1, 1'b0, 32'd5300);
    send_item(KindQuery, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(KindEdge,  1'b1, 1'b0, 32'hFFFF_FFF0);
    send_item(KindEdge,  1'b0, 1'b1, 32'h0000_0010);
    send_item(KindQuery, 1'b0, 1'b0, 32'h0000_0020);

    // Largest scale: a positive query over a longer interval, then a negative one
    write_scale(48'hFFFF_FFFF_FFFF);
    send_item(KindEdge,  1'b0, 1'b1, 32'h0000_0021);
    send_item(KindQuery, 1'b0, 1'b0, 32'h0000_0021);
    send_item(KindEdge,  1'b1, 1'b1, 32'h0000_0022);
    send_item(KindEdge,  1'b0, 1'b0, 32'h0000_0023);
    send_item(KindQuery, 1'b0, 1'b0, 32'h0000_0023);

    // A quotient of exactly the negative limit.
    write_scale(VelNegLim);
    send_item(KindQuery, 1'b0, 1'b0, 32'h0000_0024);
    clock_us = 32'h0000_0024;

    // Random phases, one scale setting each.
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      write_scale(phase_scale[p]);
      if (p == 3) hold_req = 1'b1;
      trend = TrendMixed;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n % 16 == 0) trend = trend_e'($urandom_range(0, 2));
        if (p == 2 && n == PhaseItems / 2) wait_idle();
        send_random_item(trend);
      end
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("quadrature_period_velocity_core_test: done, clean");
    end else begin
      $display("quadrature_period_velocity_core_test: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(TimeoutCycles * 2 * ClkHalf);
    $display("quadrature_period_velocity_core_test: done, errors");
    $finish;
  end

endmodule
